// File: src/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants for the greedy weighted matching engine.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int MAX_NODES_DEF   = 32;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int IDX_BITS   = 5;
    localparam int WIN_BITS   = 16;
    localparam int CNT_BITS   = 6;
    localparam int TOTAL_BITS = 20;

    localparam logic [CNT_BITS-1:0]   NODE_COUNT_RESET = 6'd32;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX        = 20'hFFFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_HOLD
    } t_gwm_state;

    typedef struct packed {
        logic clr_step;
        logic wr_en;
        logic run_start;
        logic scan_step;
        logic take;
        logic out_load;
    } t_gwm_cmd;

    typedef struct packed {
        logic clr_done;
        logic last_pair;
        logic few_nodes;
        logic best_zero;
    } t_gwm_sts;

endpackage

// File: src/gwm_ctrl.sv
// ----------------------------------------------------------------------------
// gwm_ctrl
// Sequencer for store clearing, weight writes, scan passes and result hand-off.
// ----------------------------------------------------------------------------
module gwm_ctrl
    import gwm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_op,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_gwm_sts i_sts,
    output t_gwm_cmd o_cmd
);

    t_gwm_state r_state;
    t_gwm_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_accept;
    logic       out_free;

    assign in_accept = i_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept && (i_op == OP_RUN)) begin
                    n_state = i_sts.few_nodes ? ST_HOLD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.last_pair) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = i_sts.best_zero ? ST_HOLD : ST_SCAN;
            end
            ST_HOLD: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.wr_en     = in_accept && (i_op == OP_WRITE);
                o_cmd.run_start = in_accept && (i_op == OP_RUN);
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.take = !i_sts.best_zero;
            end
            ST_HOLD: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: src/gwm_dpath.sv
// ----------------------------------------------------------------------------
// gwm_dpath
// Weight store, pair scan counters, best-edge tracking and saturating total.
// ----------------------------------------------------------------------------
module gwm_dpath
    import gwm_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_gwm_cmd              i_cmd,
    output t_gwm_sts              o_sts,
    input  logic                  i_cfg_valid,
    input  logic [CNT_BITS-1:0]   i_cfg_node_count,
    input  logic [IDX_BITS-1:0]   i_row,
    input  logic [IDX_BITS-1:0]   i_col,
    input  logic [WIN_BITS-1:0]   i_weight,
    output logic [TOTAL_BITS-1:0] o_total_weight
);

    localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);

    logic [WEIGHT_BITS-1:0] mem [DEPTH];

    logic [CNT_BITS-1:0]    r_node_count;
    logic [AW-1:0]          r_clr_addr;
    logic [IW-1:0]          r_i;
    logic [IW-1:0]          r_j;
    logic [MAX_NODES-1:0]   r_used;
    logic                   r_rd_vld;
    logic [IW-1:0]          r_rd_i;
    logic [IW-1:0]          r_rd_j;
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic [WEIGHT_BITS-1:0] r_best;
    logic [IW-1:0]          r_bi;
    logic [IW-1:0]          r_bj;
    logic [TOTAL_BITS-1:0]  r_total;
    logic [TOTAL_BITS-1:0]  r_total_out;

    logic [NW-1:0]          n_use;
    logic [31:0]            n_use_w;
    logic [31:0]            weight_w;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic                   wr_ok;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   row_end;
    logic                   pass_start;
    logic [32:0]            sum;
    logic [TOTAL_BITS-1:0]  n_total;
    logic [MAX_NODES-1:0]   take_mask;

    always_comb begin
        if (32'(r_node_count) > 32'(MAX_NODES)) begin
            n_use = NW'(MAX_NODES);
        end else begin
            n_use = NW'(r_node_count);
        end
    end

    assign n_use_w  = 32'(n_use);
    assign weight_w = 32'(i_weight);
    assign wr_data  = weight_w[WEIGHT_BITS-1:0];
    assign wr_ok    = (i_row < i_col) && (32'(i_col) < n_use_w);
    assign wr_addr  = AW'(32'(i_row) * MAX_NODES + 32'(i_col));
    assign rd_addr  = AW'(32'(r_i) * MAX_NODES + 32'(r_j));
    assign row_end  = (32'(r_j) == n_use_w - 32'd1);
    assign pass_start = i_cmd.run_start || i_cmd.take;
    assign take_mask  = (MAX_NODES'(1) << r_bi) | (MAX_NODES'(1) << r_bj);

    assign sum = 33'(r_total) + 33'(r_best);
    always_comb begin
        if (sum > 33'(TOTAL_MAX)) begin
            n_total = TOTAL_MAX;
        end else begin
            n_total = sum[TOTAL_BITS-1:0];
        end
    end

    assign o_sts.clr_done  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.last_pair = row_end && (32'(r_i) == n_use_w - 32'd2);
    assign o_sts.few_nodes = (n_use_w < 32'd2);
    assign o_sts.best_zero = (r_best == '0);

    // weight store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr_en && wr_ok) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
            r_clr_addr   <= '0;
            r_used       <= '0;
            r_rd_vld     <= 1'b0;
            r_total      <= '0;
        end else begin
            if (i_cfg_valid) r_node_count <= i_cfg_node_count;
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.run_start) begin
                r_used  <= '0;
                r_total <= '0;
            end else if (i_cmd.take) begin
                r_used  <= r_used | take_mask;
                r_total <= n_total;
            end
            r_rd_vld <= i_cmd.scan_step && !r_used[r_i] && !r_used[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pass_start) begin
            r_i <= '0;
            r_j <= IW'(1);
        end else if (i_cmd.scan_step) begin
            if (row_end) begin
                r_i <= r_i + IW'(1);
                r_j <= r_i + IW'(2);
            end else begin
                r_j <= r_j + IW'(1);
            end
        end
        r_rd_i <= r_i;
        r_rd_j <= r_j;
    end

    // strict compare keeps the first pair found on a tie
    always_ff @(posedge i_clk) begin
        if (pass_start) begin
            r_best <= '0;
            r_bi   <= '0;
            r_bj   <= '0;
        end else if (r_rd_vld && (r_rd_data > r_best)) begin
            r_best <= r_rd_data;
            r_bi   <= r_rd_i;
            r_bj   <= r_rd_j;
        end
        if (i_cmd.out_load) r_total_out <= r_total;
    end

    assign o_total_weight = r_total_out;

endmodule

// File: src/greedy_weighted_matching.sv
// ----------------------------------------------------------------------------
// greedy_weighted_matching
// Greedy maximum-weight matching over a stored upper-triangle weight matrix.
//
//   channel   direction   handshake             payload
//   input     in          i_valid / o_stall     i_op, i_row, i_col, i_weight
//   result    out         o_valid / i_stall     o_total_weight
//   config    in          i_cfg_valid / o_cfg_ready   i_cfg_node_count
//
// Weight writes are accepted back to back.
// A run makes P passes of the pair scan (at most n/2 + 1), all through the
// single read port of the weight store.
// After reset the store is cleared one entry a cycle, all MAX_NODES*MAX_NODES
// entries, with o_stall high; configuration writes are taken meanwhile.
// A finished total waits in the output register while writes continue.
// ----------------------------------------------------------------------------
module greedy_weighted_matching
    import gwm_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_op,
    input  logic [IDX_BITS-1:0]   i_row,
    input  logic [IDX_BITS-1:0]   i_col,
    input  logic [WIN_BITS-1:0]   i_weight,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [TOTAL_BITS-1:0] o_total_weight,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CNT_BITS-1:0]   i_cfg_node_count
);

    t_gwm_cmd cmd;
    t_gwm_sts sts;

    assign o_cfg_ready = 1'b1;

    gwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gwm_dpath #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_node_count (i_cfg_node_count),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_weight         (i_weight),
        .o_total_weight   (o_total_weight)
    );

endmodule

// File: src/gwm_checker.sv
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks for the greedy weighted matching engine.
// ----------------------------------------------------------------------------
module gwm_checker
    import gwm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_op,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [TOTAL_BITS-1:0] o_total_weight
);

    // no result and no input transaction right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("result or input ready right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total_weight))
        else $error("stalled result changed");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_WRITE) && !o_valid |=> !o_valid)
        else $error("weight write produced a result");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_RUN) |=> o_stall)
        else $error("input taken while a run is in progress");

endmodule

bind greedy_weighted_matching gwm_checker u_gwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_op           (i_op),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_total_weight (o_total_weight)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy weighted matching engine.
//
// A short directed table covers the reset state, the largest possible total,
// rejected weight writes, ties, and vertex counts of zero, one and above the
// maximum. Random phases follow, each at its own vertex count and idling
// mode. Most writes are legal edges with random weights; the rest are
// random, mostly rejected writes. An independent greedy model predicts totals
// not in the table. Receiver hold-offs and sender pauses fill and drain the block.
// ----------------------------------------------------------------------------
module tb;
    import gwm_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int TIMEOUT         = 10_000_000;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_PHASES      = 14;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int TAB_DEPTH       = 40;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CNT_BITS-1:0]   nodes;
        logic                  op;
        logic [IDX_BITS-1:0]   row;
        logic [IDX_BITS-1:0]   col;
        logic [WIN_BITS-1:0]   weight;
        logic                  has_total;
        logic [TOTAL_BITS-1:0] total;
    } t_dir_row;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic                  i_op             = OP_WRITE;
    logic [IDX_BITS-1:0]   i_row            = '0;
    logic [IDX_BITS-1:0]   i_col            = '0;
    logic [WIN_BITS-1:0]   i_weight         = '0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    logic [TOTAL_BITS-1:0] o_total_weight;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CNT_BITS-1:0]   i_cfg_node_count = NODE_COUNT_RESET;

    logic [WIN_BITS-1:0]   edge_w [0:MAX_NODES_DEF*MAX_NODES_DEF-1];
    logic [CNT_BITS-1:0]   cfg_nodes;
    logic [TOTAL_BITS-1:0] pending_totals [$];
    logic [TOTAL_BITS-1:0] head_total;

    t_dir_row dir_tab [0:TAB_DEPTH-1];
    int       tab_len = 0;

    int phase_nodes [0:NUM_PHASES-1] = '{5, 2, 8, 32, 3, 6, 0, 7, 63, 4, 1, 33, 8, 3};
    int mode_idle   [0:3]            = '{0, 58, 0, 18};
    int mode_stall  [0:3]            = '{0, 0, 58, 18};

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_trig = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int err_cnt   = 0;
    int n_items   = 0;
    int n_writes  = 0;
    int n_bad     = 0;
    int n_runs    = 0;
    int n_checked = 0;

    greedy_weighted_matching i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_weight         (i_weight),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_total_weight   (o_total_weight),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_node_count (i_cfg_node_count)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic int active_nodes();
        if (cfg_nodes > MAX_NODES_DEF) begin
            return MAX_NODES_DEF;
        end
        return int'(cfg_nodes);
    endfunction

    function automatic logic [TOTAL_BITS-1:0] greedy_total();
        int                  n;
        int                  a;
        int                  b;
        bit [MAX_NODES_DEF-1:0] taken;
        logic [TOTAL_BITS:0] acc;
        logic [WIN_BITS-1:0] best;
        bit                  done;
        n     = active_nodes();
        taken = '0;
        acc   = '0;
        done  = 1'b0;
        while (!done) begin
            best = '0;
            a    = 0;
            b    = 0;
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    if (!taken[i] && !taken[j] && edge_w[i*MAX_NODES_DEF+j] > best) begin
                        best = edge_w[i*MAX_NODES_DEF+j];
                        a    = i;
                        b    = j;
                    end
                end
            end
            if (best == '0) begin
                done = 1'b1;
            end else begin
                acc = acc + best;
                if (acc > {1'b0, TOTAL_MAX}) begin
                    acc = {1'b0, TOTAL_MAX};
                end
                taken[a] = 1'b1;
                taken[b] = 1'b1;
            end
        end
        return acc[TOTAL_BITS-1:0];
    endfunction

    function automatic logic [WIN_BITS-1:0] rand_weight();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 40) begin
            return WIN_BITS'($urandom);
        end else if (sel < 60) begin
            return WIN_BITS'($urandom_range(3, 1));
        end else if (sel < 70) begin
            return '0;
        end else if (sel < 85) begin
            return $urandom_range(1, 0) ? 16'hFFFF : 16'h8000;
        end
        return WIN_BITS'($urandom_range(255, 0));
    endfunction

    task automatic tab_add(input t_row_kind kind, input int nodes, input logic op,
                           input int row, input int col, input int weight,
                           input logic has_total, input int total);
        dir_tab[tab_len] = '{kind, CNT_BITS'(nodes), op, IDX_BITS'(row), IDX_BITS'(col),
                             WIN_BITS'(weight), has_total, TOTAL_BITS'(total)};
        tab_len++;
    endtask

    // one input transaction; expectation queued at the accepting edge
    task automatic drive_item(input logic op, input logic [IDX_BITS-1:0] row,
                              input logic [IDX_BITS-1:0] col,
                              input logic [WIN_BITS-1:0] weight,
                              input logic has_total, input logic [TOTAL_BITS-1:0] total);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_row    <= row;
        i_col    <= col;
        i_weight <= weight;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        n_items++;
        if (op == OP_WRITE) begin
            n_writes++;
            if (row < col && int'(col) < active_nodes()) begin
                edge_w[int'(row)*MAX_NODES_DEF+int'(col)] = weight;
            end else begin
                n_bad++;
            end
        end else begin
            n_runs++;
            pending_totals = {pending_totals, (has_total ? total : greedy_total())};
        end
    endtask

    task automatic settle_idle();
        i_valid <= 1'b0;
        while (pending_totals.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [CNT_BITS-1:0] nodes);
        i_cfg_valid      <= 1'b1;
        i_cfg_node_count <= nodes;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_nodes = nodes;
    endtask

    // receiver side: long hold-off on request, random stall otherwise
    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_totals.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("unexpected total transaction: %0d", o_total_weight);
                end
            end else begin
                head_total = pending_totals.pop_front();
                n_checked++;
                if (o_total_weight !== head_total) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("total mismatch: expected %0d, got %0d",
                                 head_total, o_total_weight);
                    end
                end
            end
        end
    end

    initial begin
        #TIMEOUT;
        $display("FAIL greedy_weighted_matching");
        $finish;
    end

    initial begin
        int       n;
        int       row;
        int       col;
        int       runs_here;
        bit       pick_run;
        t_dir_row r;

        for (int k = 0; k < MAX_NODES_DEF*MAX_NODES_DEF; k++) begin
            edge_w[k] = '0;
        end
        cfg_nodes = NODE_COUNT_RESET;

        // empty store after reset
        tab_add(ROW_ITEM, 0, OP_RUN, 0, 0, 0, 1'b1, 0);
        // perfect matching of heaviest edges over all vertices
        for (int k = 0; k < MAX_NODES_DEF/2; k++) begin
            tab_add(ROW_ITEM, 0, OP_WRITE, 2*k, 2*k+1, 16'hFFFF, 1'b0, 0);
        end
        tab_add(ROW_ITEM, 0, OP_RUN, 31, 31, 16'hFFFF, 1'b1, 1048560);
        tab_add(ROW_ITEM, 0, OP_WRITE, 3, 2, 1234, 1'b0, 0);
        tab_add(ROW_CFG, 4, OP_WRITE, 0, 0, 0, 1'b0, 0);
        tab_add(ROW_ITEM, 0, OP_RUN, 0, 0, 0, 1'b1, 131070);
        tab_add(ROW_ITEM, 0, OP_WRITE, 1, 4, 4321, 1'b0, 0);
        tab_add(ROW_ITEM, 0, OP_WRITE, 0, 1, 0, 1'b0, 0);
        // tie between equal-weight edges, the first in scan order wins
        tab_add(ROW_ITEM, 0, OP_WRITE, 0, 2, 16'hFFFF, 1'b0, 0);
        tab_add(ROW_ITEM, 0, OP_RUN, 0, 0, 0, 1'b0, 0);
        tab_add(ROW_CFG, 0, OP_WRITE, 0, 0, 0, 1'b0, 0);
        tab_add(ROW_ITEM, 0, OP_RUN, 0, 0, 0, 1'b1, 0);
        tab_add(ROW_CFG, 1, OP_WRITE, 0, 0, 0, 1'b0, 0);
        tab_add(ROW_ITEM, 0, OP_RUN, 0, 0, 0, 1'b1, 0);
        tab_add(ROW_CFG, 63, OP_WRITE, 0, 0, 0, 1'b0, 0);
        tab_add(ROW_ITEM, 0, OP_RUN, 0, 0, 0, 1'b0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int t = 0; t < tab_len; t++) begin
            r = dir_tab[t];
            if (r.kind == ROW_CFG) begin
                settle_idle();
                write_node_count(r.nodes);
            end else begin
                drive_item(r.op, r.row, r.col, r.weight, r.has_total, r.total);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            write_node_count(CNT_BITS'(phase_nodes[p]));
            idle_pct  =  mode_idle[p % 4];
            stall_pct <= mode_stall[p % 4];
            runs_here = 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 0 && k == 10) begin
                    hold_trig <= hold_trig + 1;
                end
                n = active_nodes();
                if (p == 0 && k >= 10 && k < 40) begin
                    pick_run = (k % 5 == 0);
                end else if (n >= 16) begin
                    pick_run = (runs_here < 3) && ($urandom_range(49, 0) == 0);
                end else if (n < 2) begin
                    pick_run = ($urandom_range(2, 0) == 0);
                end else begin
                    pick_run = ($urandom_range(5, 0) == 0);
                end
                if (pick_run) begin
                    runs_here++;
                    drive_item(OP_RUN, IDX_BITS'($urandom), IDX_BITS'($urandom),
                               WIN_BITS'($urandom), 1'b0, '0);
                end else if (n >= 2 && $urandom_range(99, 0) < 85) begin
                    col = $urandom_range(n - 1, 1);
                    row = $urandom_range(col - 1, 0);
                    drive_item(OP_WRITE, IDX_BITS'(row), IDX_BITS'(col), rand_weight(),
                               1'b0, '0);
                end else begin
                    drive_item(OP_WRITE, IDX_BITS'($urandom), IDX_BITS'($urandom),
                               WIN_BITS'($urandom), 1'b0, '0);
                end
            end
        end

        i_valid <= 1'b0;
        while (pending_totals.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input transactions: %0d weight writes (%0d rejected), %0d runs",
                 n_items, n_writes, n_bad, n_runs);
        $display("%0d totals compared, vertex counts 0 to 63, %0d errors", n_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS greedy_weighted_matching");
        end else begin
            $display("FAIL greedy_weighted_matching");
        end
        $finish;
    end

endmodule
